// ----- design/actis_pkg.sv -----
package actis_pkg;

    localparam int MaxRecords = 1024;
    localparam int MaxAge = 127;
    localparam int IncomeBits = 24;

    localparam int IdxW = $clog2(MaxRecords);
    localparam int CntW = $clog2(MaxRecords + 1);
    localparam int AgeW = $clog2(MaxAge + 1);
    localparam int HistDepth = MaxAge + 1;
    localparam int SumW = 34;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_QUERY = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    typedef logic [CntW-1:0] count_t;
    typedef logic [IdxW-1:0] index_t;
    typedef logic [AgeW-1:0] age_t;
    typedef logic [IncomeBits-1:0] income_t;
    typedef logic [SumW-1:0] sum_t;

endpackage

// ----- design/actis_ram.sv -----
module actis_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(Depth)-1:0] wr_addr,
    input  logic [Width-1:0]         wr_data,
    input  logic [$clog2(Depth)-1:0] rd_addr,
    output logic [Width-1:0]         rd_data
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// ----- design/age_count_and_top_income_sum.sv -----
// Age histogram and top-income sum engine.
// The input channel (s_valid/s_ready) carries one transaction per item: a
// load (s_mode 0) adds a record, a query (s_mode 1) asks for a result, a
// clear (s_mode 2) empties the data set. Loads and clears give no result;
// each query gives exactly one result transaction on m_valid/m_ready.
// One item is worked on at a time. The age histogram and the sorted income
// store each live in a single-port-read RAM, and the sequencer walks them
// one entry per cycle:
//   load  : insertion shifts smaller incomes down one place, reading one
//           entry each cycle,
//   query : adds the bins at or above the threshold age, then the top incomes,
//   clear : zeroes the histogram.
// After reset a clearing pass zeroes the histogram before the first
// transaction is taken. Reset also clears the record count
// and the sticky drop flag. A finished result waits in an output register
// while the receiver stalls; the next transaction is still accepted and its
// work proceeds, and only the next query result waits for the register.
module age_count_and_top_income_sum
    import actis_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [6:0]  s_age,
    input  logic [23:0] s_income,
    input  logic [7:0]  s_threshold_age,
    input  logic [10:0] s_top_n,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [10:0] m_adult_count,
    output logic [33:0] m_top_income_sum,
    output logic [10:0] m_record_total,
    output logic        m_records_dropped
);
    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_INS    = 3'd2;
    localparam logic [2:0] ST_HIST   = 3'd3;
    localparam logic [2:0] ST_SUM    = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;
    localparam logic [2:0] ST_HINC   = 3'd6;

    logic [2:0] state_reg, state_next;
    count_t     held_reg, held_next;
    logic       drop_reg, drop_next;
    // Walk pointer; one bit wider than the store index.
    count_t     ptr_reg, ptr_next;
    logic       first_reg, first_next;
    income_t    val_reg, val_next;
    age_t       age_reg, age_next;
    count_t     lim_reg, lim_next;
    count_t     acnt_reg, acnt_next;
    sum_t       sum_reg, sum_next;
    logic       ov_reg, ov_next;
    count_t     o_acnt_reg;
    sum_t       o_sum_reg;
    count_t     o_tot_reg;
    logic       o_drop_reg;

    logic       h_we;
    age_t       h_wa, h_ra;
    count_t     h_wd, h_rd;
    logic       i_we;
    index_t     i_wa, i_ra;
    income_t    i_wd, i_rd;

    actis_ram #(.Width(CntW), .Depth(HistDepth)) u_hist (
        .aclk(aclk), .wr_en(h_we), .wr_addr(h_wa), .wr_data(h_wd),
        .rd_addr(h_ra), .rd_data(h_rd)
    );
    actis_ram #(.Width(IncomeBits), .Depth(MaxRecords)) u_inc (
        .aclk(aclk), .wr_en(i_we), .wr_addr(i_wa), .wr_data(i_wd),
        .rd_addr(i_ra), .rd_data(i_rd)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = ov_reg;
    assign m_adult_count = o_acnt_reg;
    assign m_top_income_sum = o_sum_reg;
    assign m_record_total = o_tot_reg;
    assign m_records_dropped = o_drop_reg;

    always_comb begin
        state_next = state_reg;
        held_next = held_reg;
        drop_next = drop_reg;
        ptr_next = ptr_reg;
        first_next = 1'b0;
        val_next = val_reg;
        age_next = age_reg;
        lim_next = lim_reg;
        acnt_next = acnt_reg;
        sum_next = sum_reg;
        ov_next = ov_reg && !m_ready;
        h_we = 1'b0;
        h_wa = ptr_reg[AgeW-1:0];
        h_wd = '0;
        h_ra = ptr_reg[AgeW-1:0];
        i_we = 1'b0;
        i_wa = ptr_reg[IdxW-1:0];
        i_wd = val_reg;
        i_ra = ptr_reg[IdxW-1:0];
        unique case (state_reg)
            ST_INIT: begin
                // Histogram clearing pass, used at reset and for clears.
                h_we = 1'b1;
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == count_t'(HistDepth - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                ptr_next = '0;
                if (s_valid) begin
                    unique case (s_mode)
                        MODE_LOAD: begin
                            if (held_reg >= count_t'(MaxRecords)) begin
                                drop_next = 1'b1;
                            end else begin
                                val_next = s_income;
                                age_next = (s_age > 7'(MaxAge)) ? age_t'(MaxAge)
                                                                : age_t'(s_age);
                                ptr_next = held_reg;
                                first_next = 1'b1;
                                state_next = ST_INS;
                            end
                        end
                        MODE_QUERY: begin
                            lim_next = (count_t'(s_top_n) < held_reg) ? count_t'(s_top_n)
                                                                       : held_reg;
                            acnt_next = '0;
                            sum_next = '0;
                            first_next = 1'b1;
                            ptr_next = (s_threshold_age > 8'(MaxAge)) ? count_t'(HistDepth)
                                                                      : count_t'(s_threshold_age);
                            state_next = ST_HIST;
                        end
                        MODE_CLEAR: begin
                            held_next = '0;
                            state_next = ST_INIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_INS: begin
                // ptr is the hole; read entry ptr-1, shift it down if smaller.
                i_ra = IdxW'(ptr_reg - 1'b1);
                if (first_reg) begin
                    if (ptr_reg == '0) begin
                        i_we = 1'b1;
                        h_ra = age_reg;
                        state_next = ST_HINC;
                    end else begin
                        first_next = 1'b0;
                    end
                end else if (i_rd < val_reg) begin
                    i_we = 1'b1;
                    i_wd = i_rd;
                    ptr_next = ptr_reg - 1'b1;
                    i_ra = IdxW'(ptr_reg - 2'd2);
                    if (ptr_reg == count_t'(1)) begin
                        state_next = ST_HINC;
                        first_next = 1'b1;
                    end
                end else begin
                    i_we = 1'b1;
                    h_ra = age_reg;
                    state_next = ST_HINC;
                    first_next = 1'b1;
                end
            end
            ST_HINC: begin
                h_ra = age_reg;
                if (ptr_reg == '0 && first_reg) begin
                    i_we = 1'b1;
                end
                if (first_reg) begin
                    first_next = 1'b0;
                end else begin
                    h_we = 1'b1;
                    h_wa = age_reg;
                    h_wd = h_rd + 1'b1;
                    held_next = held_reg + 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_HIST: begin
                if (ptr_reg >= count_t'(HistDepth)) begin
                    if (!first_reg) begin
                        acnt_next = acnt_reg + h_rd;
                    end
                    ptr_next = '0;
                    first_next = 1'b1;
                    state_next = ST_SUM;
                end else begin
                    if (!first_reg) begin
                        acnt_next = acnt_reg + h_rd;
                    end
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_SUM: begin
                if (!first_reg) begin
                    sum_next = sum_reg + SumW'(i_rd);
                end
                if (ptr_reg >= lim_reg) begin
                    state_next = ST_OUT;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_OUT: begin
                if (!ov_reg || m_ready) begin
                    ov_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            held_reg <= '0;
            drop_reg <= 1'b0;
            ptr_reg <= '0;
            ov_reg <= 1'b0;
            first_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            held_reg <= held_next;
            drop_reg <= drop_next;
            ptr_reg <= ptr_next;
            ov_reg <= ov_next;
            first_reg <= first_next;
        end
        val_reg <= val_next;
        age_reg <= age_next;
        lim_reg <= lim_next;
        acnt_reg <= acnt_next;
        sum_reg <= sum_next;
        if (state_reg == ST_OUT && (!ov_reg || m_ready)) begin
            o_acnt_reg <= acnt_reg;
            o_sum_reg <= sum_reg;
            o_tot_reg <= held_reg;
            o_drop_reg <= drop_reg;
        end
    end

    // The record count never passes the store capacity.
    assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= count_t'(MaxRecords))
        else $error("record count above capacity");

    // A waiting result is not replaced while the receiver stalls.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_top_income_sum))
        else $error("result changed under stall");

    // The drop flag is sticky.
    assert property (@(posedge aclk) disable iff (!aresetn)
        drop_reg |=> drop_reg)
        else $error("drop flag fell");
endmodule
